### sv/bffs_pkg.sv
package bffs_pkg;

    // Widths of the stream words and of the bit index.
    localparam int IDX_W     = 12;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;

    // Index space reachable through a 12-bit index.
    localparam int INDEX_SPAN = 4096;

    // De Bruijn constants for the trailing-zero count of one byte.
    localparam logic [31:0] DEBRUIJN_MUL   = 32'h077C_B531;
    localparam int          DEBRUIJN_SHIFT = 27;

    localparam logic [4:0] TZ_TABLE [32] = '{
        5'd0,  5'd1,  5'd28, 5'd2,  5'd29, 5'd14, 5'd24, 5'd3,
        5'd30, 5'd22, 5'd20, 5'd15, 5'd25, 5'd17, 5'd4,  5'd8,
        5'd31, 5'd27, 5'd13, 5'd23, 5'd21, 5'd19, 5'd16, 5'd7,
        5'd26, 5'd12, 5'd18, 5'd6,  5'd11, 5'd5,  5'd10, 5'd9
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the input word
        logic rd_byte;    // read the byte that holds the indexed bit
        logic rmw;        // update that byte and record the bit
        logic look;       // take the hint, or start a scan at byte zero
        logic scan_step;  // examine one scanned byte, issue the next read
        logic clr_step;   // clear one byte of the store
        logic load_out;   // move the finished result into the output register
        logic cfg_wr;     // write the extent register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hint_valid;
        logic scan_done;
        logic clr_last;
    } status_t;

    // Position of the lowest set bit in a nonzero byte.
    function automatic logic [2:0] low_bit_pos(input logic [7:0] b);
        logic [31:0] iso;
        logic [31:0] prod;
        iso  = {24'd0, b & (~b + 8'd1)};
        prod = iso * DEBRUIJN_MUL;
        return TZ_TABLE[5'(prod >> DEBRUIJN_SHIFT)][2:0];
    endfunction

endpackage

### sv/bitmap_find_first_set.sv
// Bit map with a find-first-set search over the bits up to a programmable extent.
// Input stream (s_*): one word per request names a bit index and may set or
// clear that bit. Output stream (m_*): one word per request returns the bit
// after any write, the lowest set index within the extent and two flags.
// Configuration channel (cfg_*): writes the extent; write it only while idle.
// A request that finds a valid cached hint passes through read, update and
// hint check to the output register. Otherwise the store is scanned one
// byte per cycle from byte zero, up to the byte that holds the extent; the
// scan stops early at the first nonzero byte. The scan rate is set by the
// single read port of the byte store. One request is worked on at a time;
// the next word can be taken in the cycle after the previous one has been
// moved to the output register.
// Reset: the controller first clears the byte store, one byte per cycle
// ((BITS + 7) / 8 bytes, capped at 512; 512 with the default size), while
// s_tready stays low; the extent resets to the top of the map.
// Stalls: a result waits in the output register while m_tready is low; the
// block may accept and work on the next request meanwhile, and holds that
// result until the output register is free.
module bitmap_find_first_set #(
    parameter int BITS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] index, [12] write, [13] value, [15:14] zero
    input  logic [bffs_pkg::IN_DATA_W-1:0]     s_tdata,
    // Result words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] bit_value, [12:1] first_index, [13] none_set, [14] out_of_range,
    // [15] zero
    output logic [bffs_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Extent register write.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bffs_pkg::IDX_W-1:0]         cfg_data
);
    import bffs_pkg::*;

    localparam int STORE_BYTES = (BITS + 7) / 8;
    // A 12-bit index never reaches beyond the first 512 bytes.
    localparam int DEPTH = (STORE_BYTES < 512) ? STORE_BYTES : 512;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          cmd;
    status_t       st;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // The sequencer steps each request through read, update, hint check and scan.
    bffs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .st        (st)
    );

    // The datapath holds the extent, the cached hint and the result registers.
    bffs_dp #(
        .BITS (BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_tdata),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Byte-wide bit store with a registered read.
    bffs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### sv/bffs_ram.sv
module bffs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/bffs_ctrl.sv
module bffs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output bffs_pkg::cmd_t    cmd,
    input  bffs_pkg::status_t st
);
    import bffs_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_RMW,
        S_LOOK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.cfg_wr     = cfg_valid;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_byte = 1'b1;
                state_next  = S_RMW;
            end
            S_RMW:
            begin
                cmd.rmw    = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = st.hint_valid ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;

endmodule

### sv/bffs_dp.sv
module bffs_dp #(
    parameter int BITS = 4096,
    localparam int STORE_BYTES = (BITS + 7) / 8,
    localparam int DEPTH = (STORE_BYTES < 512) ? STORE_BYTES : 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bffs_pkg::cmd_t                    cmd,
    output bffs_pkg::status_t                 st,
    input  logic [bffs_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [bffs_pkg::IDX_W-1:0]        cfg_data,
    output logic [bffs_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                              ram_we,
    output logic [AW-1:0]                     ram_waddr,
    output logic [7:0]                        ram_wdata,
    output logic [AW-1:0]                     ram_raddr,
    input  logic [7:0]                        ram_rdata
);
    import bffs_pkg::*;

    localparam int EXT_TOP = (BITS - 1 < INDEX_SPAN - 1) ? BITS - 1 : INDEX_SPAN - 1;
    localparam logic [IDX_W-1:0] EXT_MAX = IDX_W'(EXT_TOP);

    // Request and result registers.
    logic [IDX_W-1:0]      idx_reg;
    logic                  wr_reg;
    logic                  val_reg;
    logic                  oor_reg;
    logic                  bitv_reg;
    logic [IDX_W-1:0]      first_reg;
    logic                  none_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    // Control state.
    logic [IDX_W-1:0] ext_reg;
    logic [IDX_W-1:0] hint_reg;
    logic             hint_valid_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    scan_addr_reg;

    logic [AW-1:0]    byte_addr;
    logic [AW-1:0]    last_addr;
    logic [AW-1:0]    scan_next;
    logic [7:0]       mask;
    logic [7:0]       new_byte;
    logic             do_write;
    logic             bit_now;
    logic [2:0]       tz;
    logic [IDX_W-1:0] hit_pos;
    logic             hit_ok;
    logic             byte_nz;
    logic             at_last;
    logic [IDX_W-1:0] in_index;
    logic [IDX_W-1:0] ext_next;

    assign in_index  = in_data[IDX_W-1:0];
    assign ext_next  = (cfg_data > EXT_MAX) ? EXT_MAX : cfg_data;
    assign byte_addr = idx_reg[3 +: AW];
    assign last_addr = ext_reg[3 +: AW];
    assign at_last   = (scan_addr_reg == last_addr);
    assign scan_next = at_last ? scan_addr_reg : scan_addr_reg + 1'b1;
    assign mask      = 8'd1 << idx_reg[2:0];
    assign new_byte  = val_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
    assign do_write  = wr_reg && !oor_reg;
    assign bit_now   = !oor_reg && (((do_write ? new_byte : ram_rdata) & mask) != 8'd0);
    assign byte_nz   = (ram_rdata != 8'd0);
    assign tz        = low_bit_pos(ram_rdata);
    assign hit_pos   = IDX_W'({scan_addr_reg, tz});
    assign hit_ok    = (hit_pos <= ext_reg);

    assign st.hint_valid = hint_valid_reg;
    assign st.scan_done  = byte_nz || at_last;
    assign st.clr_last   = (clr_addr_reg == AW'(DEPTH - 1));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = byte_addr;
        ram_wdata = new_byte;
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else if (cmd.rmw && do_write)
        begin
            ram_we = 1'b1;
        end

        if (cmd.look)
        begin
            ram_raddr = '0;
        end
        else if (cmd.scan_step)
        begin
            ram_raddr = scan_next;
        end
        else
        begin
            ram_raddr = byte_addr;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg        <= EXT_MAX;
            hint_reg       <= '0;
            hint_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.cfg_wr)
            begin
                ext_reg        <= ext_next;
                hint_valid_reg <= 1'b0;
            end
            else if (cmd.rmw && do_write)
            begin
                if (val_reg && hint_valid_reg && (idx_reg < hint_reg))
                begin
                    hint_reg <= idx_reg;
                end
                else if (!val_reg && hint_valid_reg && (idx_reg == hint_reg))
                begin
                    hint_valid_reg <= 1'b0;
                end
            end
            else if (cmd.scan_step && byte_nz && hit_ok)
            begin
                hint_reg       <= hit_pos;
                hint_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= in_index;
            wr_reg  <= in_data[IDX_W];
            val_reg <= in_data[IDX_W+1];
            oor_reg <= (in_index > ext_reg);
        end
        if (cmd.rmw)
        begin
            bitv_reg <= bit_now;
        end
        if (cmd.look)
        begin
            scan_addr_reg <= '0;
            first_reg     <= hint_reg;
            none_reg      <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            scan_addr_reg <= scan_next;
            if (byte_nz && hit_ok)
            begin
                first_reg <= hit_pos;
                none_reg  <= 1'b0;
            end
            else
            begin
                first_reg <= '0;
                none_reg  <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            out_reg <= {1'b0, oor_reg, none_reg, first_reg, bitv_reg};
        end
    end

    assign out_data = out_reg;

endmodule

### sv/bffs_checker.sv
module bffs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bffs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bffs_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // An out-of-range request never reports a set bit.
    a_oor_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[14] && m_tdata[0]))
        else $error("out-of-range result reports a set bit");

    // With nothing set the reported index is zero.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> (m_tdata[12:1] == '0))
        else $error("none_set with nonzero first_index");

    // A set bit in range means the search cannot come up empty.
    a_bit_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[13])
        else $error("bit set but none_set reported");

    // One request at a time: ready drops right after a word is taken.
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

endmodule

bind bitmap_find_first_set bffs_checker u_bffs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb.sv
// Self-checking bench for the bit map with a find-first-set search.
//
// Request words are sent through the slave stream. Each request is checked
// against a predictor that keeps its own copy of the byte store, of the
// cached lowest-set hint and of the extent register. The prediction is made
// when the word is accepted and is queued. Each result word that the block
// delivers is compared, field by field, with the oldest queued prediction.
//
// The run has three parts. A directed part covers the ends of the index
// range, set, clear and test-only requests, an empty map, clearing the
// hinted bit and setting a bit below it. A second directed part covers
// indexes beyond the extent and a scan that stops on a byte whose lowest
// set bit lies above the extent. A random part then runs several phases,
// each with its own extent and pattern of sender gaps and receiver stalls.
module tb;

    import bffs_pkg::*;

    // The result fields in the same bit order as m_tdata[14:0].
    typedef struct packed {
        logic             out_of_range;
        logic             none_set;
        logic [IDX_W-1:0] first_index;
        logic             bit_value;
    } lookup_result_t;

    localparam int MAP_BYTES = INDEX_SPAN / 8;

    // With about 1600 requests, some of them full scans of the store, the
    // clearing pass after reset and random stalls on both sides, a correct
    // run stays well below this bound.
    localparam int CYCLE_LIMIT = 4000000;

    // Cycles allowed for a stray result after the last expected one.
    localparam int DRAIN_CYCLES = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_data;

    // Chance, in percent, that the sender idles or the receiver stalls in a
    // given cycle. They change from one phase to the next.
    int send_idle_pct;
    int recv_stall_pct;

    // Predicted contents of the block.
    logic [7:0]       map_bytes [0:MAP_BYTES-1];
    logic [IDX_W-1:0] hint_pos;
    logic             hint_ok;
    logic [IDX_W-1:0] extent;

    lookup_result_t pending_results [$];
    int             mismatch_count;
    int             cycle_count;

    bitmap_find_first_set dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // [11:0] index, [12] write, [13] value, [15:14] zero
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [0] bit_value, [12:1] first_index, [13] none_set, [14] out_of_range,
        // [15] zero
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Position of the lowest set bit in a nonzero byte.
    function automatic int lowest_bit(input logic [7:0] v);
        int pos;
        pos = 0;
        for (int b = 7; b >= 0; b--)
        begin
            if (v[b])
                pos = b;
        end
        return pos;
    endfunction

    // Applies one request to the predicted state and returns its result.
    function automatic lookup_result_t predict_lookup(input logic [IDX_W-1:0] idx,
                                                      input logic wr,
                                                      input logic val);
        lookup_result_t r;
        logic [8:0]     byte_sel;
        logic [7:0]     mask;
        int             pos;
        r = '0;
        r.out_of_range = (idx > extent);
        if (!r.out_of_range)
        begin
            byte_sel = idx[IDX_W-1:3];
            mask     = 8'd1 << idx[2:0];
            if (wr)
            begin
                if (val)
                begin
                    map_bytes[byte_sel] = map_bytes[byte_sel] | mask;
                    // A new bit below the hint becomes the hint.
                    if (hint_ok && idx < hint_pos)
                        hint_pos = idx;
                end
                else
                begin
                    map_bytes[byte_sel] = map_bytes[byte_sel] & ~mask;
                    // Clearing the hinted bit forces a rescan.
                    if (hint_ok && idx == hint_pos)
                        hint_ok = 1'b0;
                end
            end
            r.bit_value = |(map_bytes[byte_sel] & mask);
        end
        if (hint_ok)
        begin
            r.first_index = hint_pos;
        end
        else
        begin
            r.none_set = 1'b1;
            // The scan stops at the first nonzero byte, even when its lowest
            // set bit lies above the extent.
            for (int i = 0; i <= int'(extent[IDX_W-1:3]); i++)
            begin
                if (map_bytes[i] != 8'd0)
                begin
                    pos = i * 8 + lowest_bit(map_bytes[i]);
                    if (pos <= int'(extent))
                    begin
                        hint_pos      = IDX_W'(pos);
                        hint_ok       = 1'b1;
                        r.first_index = IDX_W'(pos);
                        r.none_set    = 1'b0;
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    // Sends one request word and queues its predicted result. The valid
    // stays high on return, so that the next word may follow without a gap.
    task automatic send_request(input logic [IDX_W-1:0] idx,
                                input logic wr,
                                input logic val);
        lookup_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, wr, idx};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_lookup(idx, wr, val);
        pending_results.push_back(predicted);
    endtask

    // Ends a burst and waits until every queued result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the extent register. Called only while the block is idle.
    task automatic write_extent(input logic [IDX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        extent  = value;
        hint_ok = 1'b0;
    endtask

    // Ends of the index range, every kind of request and the hint updates,
    // all under the reset extent.
    task automatic test_corner_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(12'd0, 1'b0, 1'b0);      // empty map, full scan
        send_request(12'd4095, 1'b1, 1'b1);   // top bit, found by a scan
        send_request(12'd0, 1'b1, 1'b1);      // set below the hint
        send_request(12'd0, 1'b1, 1'b0);      // clear the hinted bit
        send_request(12'd2048, 1'b1, 1'b1);
        send_request(12'd2048, 1'b0, 1'b1);   // test only, value ignored
        send_request(12'd4095, 1'b1, 1'b0);   // clear a bit that is not hinted
        send_request(12'd2048, 1'b1, 1'b0);   // map empty again
        send_request(12'd5, 1'b1, 1'b1);
        send_request(12'd6, 1'b1, 1'b1);
        drain_results();
    endtask

    // Small extents: indexes beyond the extent, and a scan that stops on a
    // byte whose lowest set bit (5, left from above) lies over the extent.
    task automatic test_extent_limits();
        write_extent(12'd3);
        send_request(12'd3, 1'b0, 1'b0);
        send_request(12'd4, 1'b1, 1'b1);
        send_request(12'd4095, 1'b1, 1'b1);
        send_request(12'd1, 1'b1, 1'b1);
        send_request(12'd1, 1'b1, 1'b0);
        drain_results();
        write_extent(12'd0);
        send_request(12'd0, 1'b1, 1'b1);
        send_request(12'd1, 1'b0, 1'b0);
        send_request(12'd0, 1'b1, 1'b0);
        drain_results();
    endtask

    // One phase of random requests under a given extent and idle pattern.
    // Most requests fall within the extent; some aim at the hint to clear
    // it or to set a bit below it, and some are noise over the whole range.
    task automatic run_phase(input logic [IDX_W-1:0] ext, input int idle_pct,
                             input int stall_pct, input int count);
        int               pick;
        logic [IDX_W-1:0] idx;
        logic             wr;
        logic             val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_extent(ext);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            wr   = ($urandom_range(99) < 70);
            val  = 1'($urandom_range(1));
            if (pick < 15 && hint_ok)
            begin
                idx = hint_pos;
                wr  = 1'b1;
                val = 1'b0;
            end
            else if (pick < 30 && hint_ok && hint_pos != 0)
            begin
                idx = IDX_W'($urandom_range(int'(hint_pos) - 1));
                wr  = 1'b1;
                val = 1'b1;
            end
            else if (pick < 35)
                idx = ext + IDX_W'($urandom_range(8));
            else if (pick < 45)
                idx = IDX_W'($urandom_range(INDEX_SPAN - 1));
            else
                idx = IDX_W'($urandom_range(int'(ext)));
            send_request(idx, wr, val);
        end
        drain_results();
    endtask

    // Phases mix large and small extents; the full extent is kept
    // for phases in which bits stay set, so that full scans stay rare.
    task automatic test_random_traffic();
        run_phase(12'd4095, 0, 0, 200);
        run_phase(12'd100, 81, 0, 200);
        run_phase(12'd7, 0, 81, 200);
        run_phase(12'd4095, 13, 13, 150);
        run_phase(12'd0, 13, 13, 100);
        run_phase(IDX_W'($urandom_range(511)), 0, 0, 200);
        run_phase(12'd2047, 81, 0, 150);
        run_phase(12'd255, 0, 81, 200);
        run_phase(12'd4095, 13, 13, 150);
    endtask

    // Result checker: each accepted result word is compared with the
    // oldest prediction.
    always @(posedge clk)
    begin : result_check
        lookup_result_t got;
        lookup_result_t want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = lookup_result_t'(m_tdata[14:0]);
            if (pending_results.size() == 0)
            begin
                $error("result word with no request waiting: %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.bit_value !== want.bit_value)
                begin
                    $error("bit_value: expected %0d, got %0d",
                           want.bit_value, got.bit_value);
                    mismatch_count++;
                end
                if (got.first_index !== want.first_index)
                begin
                    $error("first_index: expected %0d, got %0d",
                           want.first_index, got.first_index);
                    mismatch_count++;
                end
                if (got.none_set !== want.none_set)
                begin
                    $error("none_set: expected %0d, got %0d",
                           want.none_set, got.none_set);
                    mismatch_count++;
                end
                if (got.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0d, got %0d",
                           want.out_of_range, got.out_of_range);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        hint_pos       = '0;
        hint_ok        = 1'b0;
        extent         = IDX_W'(INDEX_SPAN - 1);
        for (int i = 0; i < MAP_BYTES; i++)
            map_bytes[i] = 8'd0;

        // The block clears its store after reset; the first handshake waits
        // for that to finish.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_extent_limits();
        test_random_traffic();

        // Give a stray result word time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
